[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers shared by the speed loop modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DWPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DWPI_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DWPI_ASSERT(lbl, clk, rstn, prop, msg)
`define DWPI_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[sv/dwpi_pkg.sv]
// ----------------------------------------------------------------------------
// dwpi_pkg
// types, register codes, control word layout and microprogram of the loop
// ----------------------------------------------------------------------------
package dwpi_pkg;

  localparam int WHEELS = 2;
  localparam int CH_W   = 1;
  localparam int PC_W   = 4;

  // register indexes
  localparam logic [2:0] REG_SLEW_STEP   = 3'd0;
  localparam logic [2:0] REG_FF_GAIN     = 3'd1;
  localparam logic [2:0] REG_KP_GAIN     = 3'd2;
  localparam logic [2:0] REG_KI_GAIN     = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;
  localparam logic [2:0] REG_INTEG_CLAMP = 3'd5;

  localparam logic [14:0] RST_SLEW_STEP   = 15'd77;
  localparam logic [15:0] RST_FF_GAIN     = 16'd2294;
  localparam logic [15:0] RST_KP_GAIN     = 16'd1311;
  localparam logic [15:0] RST_KI_GAIN     = 16'd655;
  localparam logic [15:0] RST_TIME_STEP   = 16'd328;
  localparam logic [14:0] RST_INTEG_CLAMP = 15'd5120;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic               left_clamped;
    logic               right_clamped;
  } out_beat_t;

  typedef struct packed {
    logic [14:0] slew_step;
    logic [15:0] ff_gain;
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] time_step;
    logic [14:0] integ_clamp;
  } cfg_t;

  // multiplier operand select
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_TS   = 3'd1;
  localparam logic [2:0] MUL_FF   = 3'd2;
  localparam logic [2:0] MUL_KP   = 3'd3;
  localparam logic [2:0] MUL_KI   = 3'd4;

  // accumulator op
  localparam logic [1:0] ACC_HOLD   = 2'd0;
  localparam logic [1:0] ACC_CLR    = 2'd1;
  localparam logic [1:0] ACC_ADD_HI = 2'd2;
  localparam logic [1:0] ACC_ADD_LO = 2'd3;

  // alu op
  localparam logic [2:0] ALU_NOP   = 3'd0;
  localparam logic [2:0] ALU_RAMP  = 3'd1;
  localparam logic [2:0] ALU_ERR   = 3'd2;
  localparam logic [2:0] ALU_INTEG = 3'd3;
  localparam logic [2:0] ALU_DRIVE = 3'd4;
  localparam logic [2:0] ALU_CLEAR = 3'd5;

  // sequencer jump
  localparam logic [2:0] JMP_NEXT     = 3'd0;
  localparam logic [2:0] JMP_WAIT     = 3'd1;
  localparam logic [2:0] JMP_IF_CLEAR = 3'd2;
  localparam logic [2:0] JMP_IF_MORE  = 3'd3;
  localparam logic [2:0] JMP_ALWAYS   = 3'd4;

  // program steps
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] PC_RAMP     = 4'd2;
  localparam logic [PC_W-1:0] PC_ERR      = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_TS   = 4'd4;
  localparam logic [PC_W-1:0] PC_INTEG    = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_KP   = 4'd6;
  localparam logic [PC_W-1:0] PC_MUL_KI   = 4'd7;
  localparam logic [PC_W-1:0] PC_SUM      = 4'd8;
  localparam logic [PC_W-1:0] PC_DRIVE    = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd10;
  localparam logic [PC_W-1:0] PC_CLEAR    = 4'd11;

  typedef struct packed {
    logic [2:0]      mul_sel;
    logic [1:0]      acc_op;
    logic [2:0]      alu_op;
    logic [2:0]      jmp;
    logic [PC_W-1:0] tgt;
    logic            emit;
  } ctrl_t;

  typedef struct packed {
    logic kind;
    logic last;
  } dp_status_t;

  function automatic ctrl_t cw_make(logic [2:0] mul_sel, logic [1:0] acc_op,
                                    logic [2:0] alu_op, logic [2:0] jmp,
                                    logic [PC_W-1:0] tgt, logic emit);
    ctrl_t w;
    w.mul_sel = mul_sel;
    w.acc_op  = acc_op;
    w.alu_op  = alu_op;
    w.jmp     = jmp;
    w.tgt     = tgt;
    w.emit    = emit;
    return w;
  endfunction

  function automatic ctrl_t rom_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      PC_IDLE:     w = cw_make(MUL_NONE, ACC_HOLD, ALU_NOP, JMP_WAIT, PC_IDLE, 1'b0);
      PC_DISPATCH: w = cw_make(MUL_NONE, ACC_HOLD, ALU_NOP, JMP_IF_CLEAR, PC_CLEAR, 1'b0);
      PC_RAMP:     w = cw_make(MUL_NONE, ACC_HOLD, ALU_RAMP, JMP_NEXT, PC_IDLE, 1'b0);
      PC_ERR:      w = cw_make(MUL_NONE, ACC_HOLD, ALU_ERR, JMP_NEXT, PC_IDLE, 1'b0);
      PC_MUL_TS:   w = cw_make(MUL_TS, ACC_HOLD, ALU_NOP, JMP_NEXT, PC_IDLE, 1'b0);
      PC_INTEG:    w = cw_make(MUL_FF, ACC_CLR, ALU_INTEG, JMP_NEXT, PC_IDLE, 1'b0);
      PC_MUL_KP:   w = cw_make(MUL_KP, ACC_ADD_HI, ALU_NOP, JMP_NEXT, PC_IDLE, 1'b0);
      PC_MUL_KI:   w = cw_make(MUL_KI, ACC_ADD_HI, ALU_NOP, JMP_NEXT, PC_IDLE, 1'b0);
      PC_SUM:      w = cw_make(MUL_NONE, ACC_ADD_LO, ALU_NOP, JMP_NEXT, PC_IDLE, 1'b0);
      PC_DRIVE:    w = cw_make(MUL_NONE, ACC_HOLD, ALU_DRIVE, JMP_IF_MORE, PC_RAMP, 1'b0);
      PC_EMIT:     w = cw_make(MUL_NONE, ACC_HOLD, ALU_NOP, JMP_ALWAYS, PC_IDLE, 1'b1);
      PC_CLEAR:    w = cw_make(MUL_NONE, ACC_HOLD, ALU_CLEAR, JMP_ALWAYS, PC_EMIT, 1'b0);
      default:     w = cw_make(MUL_NONE, ACC_HOLD, ALU_NOP, JMP_ALWAYS, PC_IDLE, 1'b0);
    endcase
    return w;
  endfunction

endpackage

[sv/dual_wheel_ramped_pi_speed_loop.sv]
// ----------------------------------------------------------------------------
// dual_wheel_ramped_pi_speed_loop
// Two-wheel ramped PI speed loop with feedforward and drive clamp. A single
// shared 32x17 multiplier is used by a short microprogram that steps through
// the ramp, error, integral and drive sum of one wheel after the other; a
// clear beat zeroes the ramp and integral state of both wheels instead. The
// emit step stalls while the output register still holds a result that has
// not been taken. A new beat is taken only when the program is back at its
// idle step; a finished result waits in the output register, so the next
// beat may already be in work.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_wheel_ramped_pi_speed_loop
  import dwpi_pkg::*;
#(
  parameter int CHANNELS = 2
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  localparam int ACTIVE = (CHANNELS < WHEELS) ? CHANNELS : WHEELS;

  cfg_t       cfg_r;
  ctrl_t      cw;
  dp_status_t st;
  out_beat_t  res;
  out_beat_t  out_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       idle;
  logic       in_fire;
  logic       out_busy;
  logic       emit_go;

  assign in_ready  = idle;
  assign in_fire   = in_valid && idle;
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_go   = cw.emit && !out_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slew_step   <= RST_SLEW_STEP;
      cfg_r.ff_gain     <= RST_FF_GAIN;
      cfg_r.kp_gain     <= RST_KP_GAIN;
      cfg_r.ki_gain     <= RST_KI_GAIN;
      cfg_r.time_step   <= RST_TIME_STEP;
      cfg_r.integ_clamp <= RST_INTEG_CLAMP;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SLEW_STEP:   cfg_r.slew_step   <= cfg_wdata[14:0];
        REG_FF_GAIN:     cfg_r.ff_gain     <= cfg_wdata;
        REG_KP_GAIN:     cfg_r.kp_gain     <= cfg_wdata;
        REG_KI_GAIN:     cfg_r.ki_gain     <= cfg_wdata;
        REG_TIME_STEP:   cfg_r.time_step   <= cfg_wdata;
        REG_INTEG_CLAMP: cfg_r.integ_clamp <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  dwpi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (out_busy),
    .st       (st),
    .cw       (cw),
    .idle     (idle)
  );

  dwpi_dp #(
    .ACTIVE (ACTIVE)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .cfg     (cfg_r),
    .cw      (cw),
    .st      (st),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= res;
    end
  end

  `DWPI_ASSERT(a_left_range, clk, rst_n, out_valid_r |-> (out_data_r.drive_left <= 16'sd16384 && out_data_r.drive_left >= -16'sd16384), "left drive out of range")
  `DWPI_ASSERT(a_left_flag, clk, rst_n, (out_valid_r && out_data_r.left_clamped) |-> (out_data_r.drive_left == 16'sd16384 || out_data_r.drive_left == -16'sd16384), "left flag without full drive")
  `DWPI_ASSERT_NEVER(a_right_flag, clk, rst_n, out_valid_r && out_data_r.right_clamped && out_data_r.drive_right != 16'sd16384 && out_data_r.drive_right != -16'sd16384, "right flag without full drive")

endmodule

[sv/dwpi_seq.sv]
// ----------------------------------------------------------------------------
// dwpi_seq
// step counter and control store; one control word per step
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwpi_seq
  import dwpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_busy,
  input  dp_status_t st,
  output ctrl_t      cw,
  output logic       idle
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] pc_inc;

  assign cw     = rom_word(pc_r);
  assign idle   = (pc_r == PC_IDLE);
  assign pc_inc = pc_r + 1'b1;

  always_comb begin
    unique case (cw.jmp)
      JMP_NEXT:     pc_nxt = pc_inc;
      JMP_WAIT:     pc_nxt = in_fire ? pc_inc : pc_r;
      JMP_IF_CLEAR: pc_nxt = st.kind ? cw.tgt : pc_inc;
      JMP_IF_MORE:  pc_nxt = st.last ? pc_inc : cw.tgt;
      JMP_ALWAYS:   pc_nxt = cw.tgt;
      default:      pc_nxt = PC_IDLE;
    endcase
    // result slot still full
    if (cw.emit && out_busy) begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `DWPI_ASSERT(a_fire_dispatch, clk, rst_n, in_fire |=> pc_r == PC_DISPATCH, "beat not dispatched")
  `DWPI_ASSERT(a_emit_hold, clk, rst_n, (cw.emit && out_busy) |=> pc_r == PC_EMIT, "emit step left while busy")

endmodule

[sv/dwpi_dp.sv]
// ----------------------------------------------------------------------------
// dwpi_dp
// wheel datapath: ramp, error, clamped integral and shared multiplier with
// accumulator for the drive sum
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwpi_dp
  import dwpi_pkg::*;
#(
  parameter int ACTIVE = 2
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  in_beat_t   in_data,
  input  cfg_t       cfg,
  input  ctrl_t      cw,
  output dp_status_t st,
  output out_beat_t  res
);

  localparam logic [CH_W-1:0] ACT_LAST = CH_W'(ACTIVE - 1);

  in_beat_t           in_r;
  logic [CH_W-1:0]    ch_r;
  logic [CH_W-1:0]    ch_nxt;
  logic signed [15:0] ramp_r  [WHEELS];
  logic signed [31:0] integ_r [WHEELS];
  logic signed [15:0] spd_r;
  logic signed [16:0] err_r;
  logic signed [47:0] prod_r;
  logic signed [50:0] acc_r;
  logic signed [15:0] drive_r [WHEELS];
  logic               flag_r  [WHEELS];

  logic signed [15:0] tgt;
  logic signed [15:0] raw;
  logic signed [15:0] ramp_cur;
  logic signed [31:0] integ_cur;
  logic signed [15:0] spd_nxt;
  logic signed [16:0] diff;
  logic signed [16:0] lim;
  logic signed [16:0] ramp_sum;
  logic signed [15:0] ramp_nxt;
  logic signed [16:0] err_nxt;
  logic signed [31:0] ilim;
  logic signed [34:0] isum;
  logic signed [31:0] integ_nxt;
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_full;
  logic signed [50:0] acc_nxt;
  logic signed [50:0] rnd;
  logic signed [24:0] q;
  logic signed [15:0] drive_nxt;
  logic               flag_nxt;

  assign tgt       = (ch_r != '0) ? in_r.target_right : in_r.target_left;
  assign raw       = (ch_r != '0) ? in_r.speed_right : in_r.speed_left;
  assign ramp_cur  = ramp_r[ch_r];
  assign integ_cur = integ_r[ch_r];

  // ramp slew
  always_comb begin
    spd_nxt = (raw == 16'sh8000) ? 16'sh7fff : -raw;
    lim     = signed'({2'b00, cfg.slew_step});
    diff    = 17'(tgt) - 17'(ramp_cur);
    if (diff > lim) begin
      diff = lim;
    end else if (diff < -lim) begin
      diff = -lim;
    end
    ramp_sum = 17'(ramp_cur) + diff;
    ramp_nxt = ramp_sum[15:0];
    err_nxt  = 17'(ramp_cur) - 17'(spd_r);
  end

  // integral clamp
  always_comb begin
    ilim = signed'({1'b0, cfg.integ_clamp, 16'h0000});
    isum = 35'(integ_cur) + 35'(prod_r);
    if (isum > 35'(ilim)) begin
      isum = 35'(ilim);
    end else if (isum < -35'(ilim)) begin
      isum = -35'(ilim);
    end
    integ_nxt = isum[31:0];
  end

  // shared multiplier
  always_comb begin
    unique case (cw.mul_sel)
      MUL_TS: begin
        mul_a = 32'(err_r);
        mul_b = signed'({1'b0, cfg.time_step});
      end
      MUL_FF: begin
        mul_a = 32'(ramp_cur);
        mul_b = signed'({1'b0, cfg.ff_gain});
      end
      MUL_KP: begin
        mul_a = 32'(err_r);
        mul_b = signed'({1'b0, cfg.kp_gain});
      end
      MUL_KI: begin
        mul_a = integ_cur;
        mul_b = signed'({1'b0, cfg.ki_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  always_comb begin
    unique case (cw.acc_op)
      ACC_HOLD:   acc_nxt = acc_r;
      ACC_CLR:    acc_nxt = '0;
      ACC_ADD_HI: acc_nxt = acc_r + (51'(prod_r) <<< 16);
      ACC_ADD_LO: acc_nxt = acc_r + 51'(prod_r);
      default:    acc_nxt = acc_r;
    endcase
  end

  // round to q2.14 and clamp
  always_comb begin
    rnd       = acc_r + 51'sd33554432;
    q         = rnd[50:26];
    drive_nxt = q[15:0];
    flag_nxt  = 1'b0;
    if (q > 25'sd16384) begin
      drive_nxt = 16'sd16384;
      flag_nxt  = 1'b1;
    end else if (q < -25'sd16384) begin
      drive_nxt = -16'sd16384;
      flag_nxt  = 1'b1;
    end
  end

  always_comb begin
    ch_nxt = ch_r;
    if (in_fire) begin
      ch_nxt = '0;
    end else if (cw.alu_op == ALU_DRIVE && ch_r != ACT_LAST) begin
      ch_nxt = ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r    <= '0;
      ramp_r  <= '{default: '0};
      integ_r <= '{default: '0};
    end else begin
      ch_r <= ch_nxt;
      unique case (cw.alu_op)
        ALU_RAMP:  ramp_r[ch_r]  <= ramp_nxt;
        ALU_INTEG: integ_r[ch_r] <= integ_nxt;
        ALU_CLEAR: begin
          ramp_r  <= '{default: '0};
          integ_r <= '{default: '0};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_full[47:0];
    acc_r  <= acc_nxt;
    if (in_fire) begin
      in_r    <= in_data;
      drive_r <= '{default: '0};
      flag_r  <= '{default: 1'b0};
    end
    if (cw.alu_op == ALU_RAMP) begin
      spd_r <= spd_nxt;
    end
    if (cw.alu_op == ALU_ERR) begin
      err_r <= err_nxt;
    end
    if (cw.alu_op == ALU_DRIVE) begin
      drive_r[ch_r] <= drive_nxt;
      flag_r[ch_r]  <= flag_nxt;
    end
  end

  assign st.kind = in_r.kind;
  assign st.last = (ch_r == ACT_LAST);

  assign res.drive_left    = drive_r[0];
  assign res.drive_right   = drive_r[1];
  assign res.left_clamped  = flag_r[0];
  assign res.right_clamped = flag_r[1];

  `DWPI_ASSERT(a_integ_bound, clk, rst_n, cw.alu_op == ALU_INTEG |=> (integ_cur <= ilim && integ_cur >= -ilim), "integral beyond its limit")

endmodule
